FILE: rtl/ttb_pkg.sv
// Shared types and constants for the triangle tangent/binormal block.
// Used by ttb_ctrl, ttb_datapath, the top level and the port checker.
package ttb_pkg;

    typedef struct packed {
        logic               model_start;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic               degenerate;
    } frame_t;

    localparam logic [31:0] DET_THRESHOLD_RESET = 32'd4295;
    localparam logic [15:0] ONE_Q14             = 16'd16384;
    localparam logic [15:0] Q14_MAX             = 16'd32767;
    localparam int          NORM_BITS           = 30;
    localparam int          COARSE_SHIFT        = 8;
    localparam int          SQRT_STEPS          = 32;
    localparam int          DIV_STEPS           = 16;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MUL,
        OP_LOAD,
        OP_DIFF_DET,
        OP_DIFF_VEC,
        OP_SHIFT,
        OP_SUM,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_SAVE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        MS_DU1_DV2,
        MS_DU2_DV1,
        MS_DV2_E1,
        MS_DV1_E2,
        MS_DU1_E2,
        MS_DU2_E1,
        MS_SQ
    } mul_sel_t;

    typedef struct packed {
        op_t        op;
        mul_sel_t   sel;
        logic [1:0] idx;
        logic       vec;
    } cmd_t;

    typedef struct packed {
        logic det_ok;
        logic need_shift;
        logic out_busy;
    } stat_t;

endpackage

FILE: rtl/ttb_datapath.sv
// Datapath: vertex store, deltas, shared multiplier, accumulator,
// normalize shifter, iterative square root and divider, result register.
// Depends on ttb_pkg; driven by commands from ttb_ctrl.
module ttb_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  ttb_pkg::cmd_t    cmd,
    input  ttb_pkg::vertex_t s_data,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    output ttb_pkg::stat_t   stat,
    output logic             m_valid,
    input  logic             m_ready,
    output ttb_pkg::frame_t  m_data
);

    logic signed [31:0] in_pos [3];
    logic signed [31:0] held_pos_reg [2][3];
    logic signed [31:0] held_tex_reg [2][2];
    logic signed [32:0] e1_reg [3];
    logic signed [32:0] e2_reg [3];
    logic signed [32:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic [31:0]        threshold_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic signed [66:0] diff;
    logic [66:0]        diff_abs;

    logic               det_neg_reg;
    logic [65:0]        det_mag_reg;
    logic [65:0]        mag_reg [3];
    logic               neg_reg [3];
    logic [65:0]        mag_or;
    logic               coarse;

    logic [61:0]        sum_reg;
    logic [61:0]        sq_x_reg;
    logic [62:0]        sq_res_reg, sq_bit_reg;
    logic [63:0]        sq_trial;
    logic [30:0]        root;

    logic [45:0]        div_num;
    logic [31:0]        div_rem_reg;
    logic [15:0]        div_low_reg, div_q_reg;
    logic [32:0]        div_rem2, div_den;
    logic [15:0]        q_sat;
    logic               q_neg;
    logic signed [15:0] q_val;

    logic signed [15:0] tan_reg [3];
    logic signed [15:0] bin_reg [3];
    logic               out_valid_reg;
    ttb_pkg::frame_t    out_data_reg;

    assign in_pos[0] = s_data.pos_x;
    assign in_pos[1] = s_data.pos_y;
    assign in_pos[2] = s_data.pos_z;

    // operand select for the shared multiplier
    always_comb begin
        unique case (cmd.sel)
            ttb_pkg::MS_DU1_DV2: begin mul_a = du1_reg; mul_b = dv2_reg; end
            ttb_pkg::MS_DU2_DV1: begin mul_a = du2_reg; mul_b = dv1_reg; end
            ttb_pkg::MS_DV2_E1:  begin mul_a = dv2_reg; mul_b = e1_reg[cmd.idx]; end
            ttb_pkg::MS_DV1_E2:  begin mul_a = dv1_reg; mul_b = e2_reg[cmd.idx]; end
            ttb_pkg::MS_DU1_E2:  begin mul_a = du1_reg; mul_b = e2_reg[cmd.idx]; end
            ttb_pkg::MS_DU2_E1:  begin mul_a = du2_reg; mul_b = e1_reg[cmd.idx]; end
            ttb_pkg::MS_SQ: begin
                mul_a = $signed({3'b000, mag_reg[cmd.idx][ttb_pkg::NORM_BITS-1:0]});
                mul_b = mul_a;
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign diff     = acc_reg - {prod_reg[65], prod_reg};
    assign diff_abs = diff[66] ? -diff : diff;

    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign coarse = |mag_or[65:ttb_pkg::NORM_BITS+ttb_pkg::COARSE_SHIFT];

    assign sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign root     = sq_res_reg[30:0];

    assign div_num  = {1'b0, mag_reg[cmd.idx][ttb_pkg::NORM_BITS-1:0], 15'd0}
                    + {15'd0, root};
    assign div_rem2 = {div_rem_reg, div_low_reg[15]};
    assign div_den  = {1'b0, root, 1'b0};

    assign q_sat = (root == '0) ? 16'd0 :
                   (div_q_reg > ttb_pkg::Q14_MAX) ? ttb_pkg::Q14_MAX : div_q_reg;
    assign q_neg = (neg_reg[cmd.idx] ^ det_neg_reg) && (q_sat != '0);
    assign q_val = q_neg ? -$signed(q_sat) : $signed(q_sat);

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            ttb_pkg::OP_CAPTURE: begin
                if (cmd.idx[1]) begin
                    for (int i = 0; i < 3; i++) begin
                        e1_reg[i] <= {held_pos_reg[1][i][31], held_pos_reg[1][i]}
                                   - {held_pos_reg[0][i][31], held_pos_reg[0][i]};
                        e2_reg[i] <= {in_pos[i][31], in_pos[i]}
                                   - {held_pos_reg[0][i][31], held_pos_reg[0][i]};
                    end
                    du1_reg <= {held_tex_reg[1][0][31], held_tex_reg[1][0]}
                             - {held_tex_reg[0][0][31], held_tex_reg[0][0]};
                    dv1_reg <= {held_tex_reg[1][1][31], held_tex_reg[1][1]}
                             - {held_tex_reg[0][1][31], held_tex_reg[0][1]};
                    du2_reg <= {s_data.tex_u[31], s_data.tex_u}
                             - {held_tex_reg[0][0][31], held_tex_reg[0][0]};
                    dv2_reg <= {s_data.tex_v[31], s_data.tex_v}
                             - {held_tex_reg[0][1][31], held_tex_reg[0][1]};
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        held_pos_reg[cmd.idx[0]][i] <= in_pos[i];
                    end
                    held_tex_reg[cmd.idx[0]][0] <= s_data.tex_u;
                    held_tex_reg[cmd.idx[0]][1] <= s_data.tex_v;
                end
            end
            ttb_pkg::OP_MUL:      prod_reg <= mul_a * mul_b;
            ttb_pkg::OP_LOAD:     acc_reg  <= {prod_reg[65], prod_reg};
            ttb_pkg::OP_DIFF_DET: begin
                det_neg_reg <= diff[66];
                det_mag_reg <= diff_abs[65:0];
            end
            ttb_pkg::OP_DIFF_VEC: begin
                mag_reg[cmd.idx] <= diff_abs[65:0];
                neg_reg[cmd.idx] <= diff[66];
            end
            ttb_pkg::OP_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= coarse ? (mag_reg[i] >> ttb_pkg::COARSE_SHIFT)
                                         : (mag_reg[i] >> 1);
                end
            end
            ttb_pkg::OP_SUM: begin
                sum_reg <= ((cmd.idx == 2'd0) ? 62'd0 : sum_reg) + prod_reg[61:0];
            end
            ttb_pkg::OP_SQRT_INIT: begin
                sq_x_reg   <= sum_reg;
                sq_res_reg <= '0;
                sq_bit_reg <= {1'b1, 62'd0};
            end
            ttb_pkg::OP_SQRT_STEP: begin
                if ({2'b00, sq_x_reg} >= sq_trial) begin
                    sq_x_reg   <= sq_x_reg - sq_trial[61:0];
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ttb_pkg::OP_DIV_INIT: begin
                div_rem_reg <= {2'b00, div_num[45:16]};
                div_low_reg <= div_num[15:0];
                div_q_reg   <= '0;
            end
            ttb_pkg::OP_DIV_STEP: begin
                if (div_rem2 >= div_den) begin
                    div_rem_reg <= 32'(div_rem2 - div_den);
                    div_q_reg   <= {div_q_reg[14:0], 1'b1};
                end else begin
                    div_rem_reg <= div_rem2[31:0];
                    div_q_reg   <= {div_q_reg[14:0], 1'b0};
                end
                div_low_reg <= {div_low_reg[14:0], 1'b0};
            end
            ttb_pkg::OP_DIV_SAVE: begin
                if (cmd.vec) bin_reg[cmd.idx] <= q_val;
                else         tan_reg[cmd.idx] <= q_val;
            end
            ttb_pkg::OP_EMIT: begin
                if (stat.det_ok) begin
                    out_data_reg.tangent_x  <= tan_reg[0];
                    out_data_reg.tangent_y  <= tan_reg[1];
                    out_data_reg.tangent_z  <= tan_reg[2];
                    out_data_reg.binormal_x <= bin_reg[0];
                    out_data_reg.binormal_y <= bin_reg[1];
                    out_data_reg.binormal_z <= bin_reg[2];
                end else begin
                    out_data_reg.tangent_x  <= ttb_pkg::ONE_Q14;
                    out_data_reg.tangent_y  <= '0;
                    out_data_reg.tangent_z  <= '0;
                    out_data_reg.binormal_x <= '0;
                    out_data_reg.binormal_y <= ttb_pkg::ONE_Q14;
                    out_data_reg.binormal_z <= '0;
                end
                out_data_reg.degenerate <= ~stat.det_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= ttb_pkg::DET_THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) threshold_reg <= cfg_wr_data;
            if (cmd.op == ttb_pkg::OP_EMIT) out_valid_reg <= 1'b1;
            else if (m_ready)               out_valid_reg <= 1'b0;
        end
    end

    // zero determinant always falls back to the defaults
    assign stat.det_ok     = (det_mag_reg != '0) && (det_mag_reg >= {34'd0, threshold_reg});
    assign stat.need_shift = |mag_or[65:ttb_pkg::NORM_BITS];
    assign stat.out_busy   = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: rtl/ttb_ctrl.sv
// Controller: vertex grouping and the command sequence for one triangle.
// Depends on ttb_pkg; drives ttb_datapath through cmd_t, reads stat_t.
module ttb_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           model_start,
    input  ttb_pkg::stat_t stat,
    output ttb_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DET_M1, S_DET_L, S_DET_M2, S_DET_D, S_DET_CHK,
        S_V_M1, S_V_L, S_V_M2, S_V_D, S_SHIFT, S_SQ_M, S_SQ_A,
        S_SQRT_I, S_SQRT, S_DIV_I, S_DIV, S_DIV_S, S_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  comp_reg, comp_next;
    logic        vec_reg, vec_next;
    logic [4:0]  iter_reg, iter_next;
    logic [1:0]  slot;

    assign s_ready = (state_reg == S_IDLE);
    assign slot    = model_start ? 2'd0 : phase_reg;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        comp_next  = comp_reg;
        vec_next   = vec_reg;
        iter_next  = iter_reg;
        cmd.op     = ttb_pkg::OP_NONE;
        cmd.sel    = ttb_pkg::MS_DU1_DV2;
        cmd.idx    = comp_reg;
        cmd.vec    = vec_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op  = ttb_pkg::OP_CAPTURE;
                    cmd.idx = slot;
                    if (slot[1]) begin
                        phase_next = 2'd0;
                        state_next = S_DET_M1;
                    end else begin
                        phase_next = slot + 2'd1;
                    end
                end
            end
            S_DET_M1: begin
                cmd.op = ttb_pkg::OP_MUL; cmd.sel = ttb_pkg::MS_DU1_DV2;
                state_next = S_DET_L;
            end
            S_DET_L: begin cmd.op = ttb_pkg::OP_LOAD; state_next = S_DET_M2; end
            S_DET_M2: begin
                cmd.op = ttb_pkg::OP_MUL; cmd.sel = ttb_pkg::MS_DU2_DV1;
                state_next = S_DET_D;
            end
            S_DET_D: begin cmd.op = ttb_pkg::OP_DIFF_DET; state_next = S_DET_CHK; end
            S_DET_CHK: begin
                comp_next  = 2'd0;
                vec_next   = 1'b0;
                state_next = stat.det_ok ? S_V_M1 : S_EMIT;
            end
            S_V_M1: begin
                cmd.op  = ttb_pkg::OP_MUL;
                cmd.sel = vec_reg ? ttb_pkg::MS_DU1_E2 : ttb_pkg::MS_DV2_E1;
                state_next = S_V_L;
            end
            S_V_L: begin cmd.op = ttb_pkg::OP_LOAD; state_next = S_V_M2; end
            S_V_M2: begin
                cmd.op  = ttb_pkg::OP_MUL;
                cmd.sel = vec_reg ? ttb_pkg::MS_DU2_E1 : ttb_pkg::MS_DV1_E2;
                state_next = S_V_D;
            end
            S_V_D: begin
                cmd.op = ttb_pkg::OP_DIFF_VEC;
                if (comp_reg == 2'd2) begin
                    comp_next  = 2'd0;
                    state_next = S_SHIFT;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_V_M1;
                end
            end
            S_SHIFT: begin
                // drop low bits until every component fits the square root range
                if (stat.need_shift) cmd.op = ttb_pkg::OP_SHIFT;
                else                 state_next = S_SQ_M;
            end
            S_SQ_M: begin
                cmd.op = ttb_pkg::OP_MUL; cmd.sel = ttb_pkg::MS_SQ;
                state_next = S_SQ_A;
            end
            S_SQ_A: begin
                cmd.op = ttb_pkg::OP_SUM;
                if (comp_reg == 2'd2) begin
                    comp_next  = 2'd0;
                    state_next = S_SQRT_I;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_SQ_M;
                end
            end
            S_SQRT_I: begin
                cmd.op = ttb_pkg::OP_SQRT_INIT;
                iter_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op    = ttb_pkg::OP_SQRT_STEP;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(ttb_pkg::SQRT_STEPS - 1)) state_next = S_DIV_I;
            end
            S_DIV_I: begin
                cmd.op = ttb_pkg::OP_DIV_INIT;
                iter_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op    = ttb_pkg::OP_DIV_STEP;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(ttb_pkg::DIV_STEPS - 1)) state_next = S_DIV_S;
            end
            S_DIV_S: begin
                cmd.op = ttb_pkg::OP_DIV_SAVE;
                if (comp_reg != 2'd2) begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DIV_I;
                end else if (!vec_reg) begin
                    comp_next  = 2'd0;
                    vec_next   = 1'b1;
                    state_next = S_V_M1;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register can take the transaction
                if (!stat.out_busy) begin
                    cmd.op     = ttb_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= 2'd0;
            comp_reg  <= 2'd0;
            vec_reg   <= 1'b0;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
            vec_reg   <= vec_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

FILE: rtl/triangle_tangent_binormal.sv
// Top level: triangle tangent/binormal from vertex positions and UVs.
// Depends on ttb_pkg, ttb_ctrl and ttb_datapath.
//
//  channel  | direction | handshake            | payload
//  s_       | in        | s_valid / s_ready    | s_data  (ttb_pkg::vertex_t)
//  m_       | out       | m_valid / m_ready    | m_data  (ttb_pkg::frame_t)
//  cfg_     | in        | cfg_wr_en            | cfg_wr_data (det_threshold)
//
// First and second vertex of a triangle: each is stored as it is accepted.
// Third vertex: the determinant, then per vector the products, normalize
// shifts, squares, the square root and three 16-step divides, then the emit;
// the work runs serially through the shared multiplier and the bit-serial root
// and divider. Degenerate triangles go from the determinant check straight
// to the emit.
// s_ready is low while a triangle is in work; a stalled m_ready holds only the
// final transfer. Reset (aresetn, synchronous) clears grouping and the output.
module triangle_tangent_binormal (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ttb_pkg::vertex_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ttb_pkg::frame_t  m_data,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data
);

    ttb_pkg::cmd_t  cmd;
    ttb_pkg::stat_t stat;

    ttb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .model_start (s_data.model_start),
        .stat        (stat),
        .cmd         (cmd)
    );

    ttb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: rtl/ttb_checker.sv
// Port-level checker for triangle_tangent_binormal, bound to the top level.
// Depends on ttb_pkg.
module ttb_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input ttb_pkg::frame_t  m_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_degenerate_defaults: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.tangent_x == ttb_pkg::ONE_Q14 && m_data.tangent_y == '0 &&
            m_data.tangent_z == '0 && m_data.binormal_x == '0 &&
            m_data.binormal_y == ttb_pkg::ONE_Q14 && m_data.binormal_z == '0)
        else $error("degenerate result without default vectors");

    a_ready_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("input not reopened after result");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result appeared right after an input transaction");

endmodule

bind triangle_tangent_binormal ttb_checker u_ttb_checker (.*);
